>>> rtl/wst_pkg.sv
// Shared types and codes for the weighted sum tree sampler.
// Transfer payloads, operation and status codes, controller states. No dependencies.
package wst_pkg;

  localparam int OP_W         = 2;
  localparam int NODE_IDX_W   = 10;
  localparam int IN_WEIGHT_W  = 32;
  localparam int TOTAL_W      = 48;
  localparam int NODES_HELD_W = 11;
  localparam int STATUS_W     = 2;

  localparam logic [OP_W-1:0] OP_APPEND     = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_WEIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [NODE_IDX_W-1:0]  node_index;
    logic [IN_WEIGHT_W-1:0] weight;
    logic [TOTAL_W-1:0]     cutoff;
  } wst_in_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0]   chosen_node;
    logic [TOTAL_W-1:0]      total_weight;
    logic [NODES_HELD_W-1:0] nodes_held;
    logic [STATUS_W-1:0]     status;
  } wst_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_RD1,
    S_SET_RD2,
    S_SET_SUM,
    S_UP_START,
    S_UP,
    S_WALK_RD,
    S_WALK,
    S_DONE
  } wst_state_t;

endpackage

>>> rtl/wst_in_if.sv
// Input channel: valid/ready handshake carrying one request item.
// Depends on wst_pkg.
interface wst_in_if;
  logic            valid;
  logic            ready;
  wst_pkg::wst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wst_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on wst_pkg.
interface wst_out_if;
  logic              valid;
  logic              ready;
  wst_pkg::wst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/wst_engine.sv
// Sum tree controller: weight and total memories plus the update and sample walks.
// Depends on wst_pkg and wst_ram.
module wst_engine #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wst_pkg::wst_in_t  in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output wst_pkg::wst_out_t res_data
);
  import wst_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CHD_W = IDX_W + 2;

  wst_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [TOTAL_W-1:0]      root_tot_r, root_tot_nxt;
  logic [IDX_W-1:0]        node_r, node_nxt;
  logic [TOTAL_W-1:0]      cur_tot_r, cur_tot_nxt;
  logic [WEIGHT_BITS-1:0]  wt_r, wt_nxt;
  logic [TOTAL_W-1:0]      rem_r, rem_nxt;
  logic                    sib_ok_r, sib_ok_nxt;
  logic [NODE_IDX_W-1:0]   chosen_r, chosen_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;

  logic                    w_we, t_we;
  logic [IDX_W-1:0]        w_waddr, w_raddr, t_waddr, t_raddr;
  logic [WEIGHT_BITS-1:0]  w_wdata, w_rdata;
  logic [TOTAL_W-1:0]      t_wdata, t_rdata;

  logic [CHD_W-1:0]        lc, rc, sib, nxt_node, nxt_lc;
  logic                    lc_ok, rc_ok;
  logic [IDX_W-1:0]        par;
  logic [WEIGHT_BITS-1:0]  in_wt;
  logic [TOTAL_W-1:0]      up_sum, wt_ext, diff;
  logic [TOTAL_W:0]        diff2;
  logic                    take, go_right;

  wst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES)) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  wst_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_NODES)) u_totals (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign lc     = (CHD_W'(node_r) << 1) + CHD_W'(1);
  assign rc     = lc + CHD_W'(1);
  assign lc_ok  = 32'(lc) < 32'(count_r);
  assign rc_ok  = 32'(rc) < 32'(count_r);
  assign par    = (node_r - IDX_W'(1)) >> 1;
  assign sib    = node_r[0] ? CHD_W'(node_r) + CHD_W'(1) : CHD_W'(node_r) - CHD_W'(1);
  assign in_wt  = WEIGHT_BITS'(in_data.weight);
  assign wt_ext = TOTAL_W'(w_rdata);
  assign up_sum = wt_ext + cur_tot_r + (sib_ok_r ? t_rdata : '0);

  // sample step: residual against node weight, then against left subtree
  assign take     = rem_r <= wt_ext;
  assign diff     = rem_r - wt_ext;
  assign diff2    = {1'b0, diff} - {1'b0, t_rdata};
  assign go_right = !diff2[TOTAL_W] && (diff2[TOTAL_W-1:0] != '0);
  assign nxt_node = go_right ? rc : lc;
  assign nxt_lc   = (nxt_node << 1) + CHD_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res_data.chosen_node  = chosen_r;
    res_data.total_weight = (count_r != '0) ? root_tot_r : '0;
    res_data.nodes_held   = NODES_HELD_W'(count_r);
    res_data.status       = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    root_tot_r <= root_tot_nxt;
    node_r     <= node_nxt;
    cur_tot_r  <= cur_tot_nxt;
    wt_r       <= wt_nxt;
    rem_r      <= rem_nxt;
    sib_ok_r   <= sib_ok_nxt;
    chosen_r   <= chosen_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    root_tot_nxt = root_tot_r;
    node_nxt     = node_r;
    cur_tot_nxt  = cur_tot_r;
    wt_nxt       = wt_r;
    rem_nxt      = rem_r;
    sib_ok_nxt   = sib_ok_r;
    chosen_nxt   = chosen_r;
    status_nxt   = status_r;
    w_we         = 1'b0;
    w_waddr      = node_r;
    w_wdata      = wt_r;
    w_raddr      = node_r;
    t_we         = 1'b0;
    t_waddr      = node_r;
    t_wdata      = cur_tot_r;
    t_raddr      = lc[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          chosen_nxt = '0;
          case (in_data.operation)
            OP_APPEND: begin
              if (32'(count_r) >= 32'(MAX_NODES)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                node_nxt    = count_r[IDX_W-1:0];
                chosen_nxt  = NODE_IDX_W'(count_r);
                wt_nxt      = in_wt;
                cur_tot_nxt = TOTAL_W'(in_wt);
                count_nxt   = count_r + CNT_W'(1);
                state_nxt   = S_UP_START;
              end
            end
            OP_SET_WEIGHT: begin
              chosen_nxt = in_data.node_index;
              if (32'(in_data.node_index) >= 32'(count_r)) begin
                status_nxt = ST_BAD_INDEX;
                state_nxt  = S_DONE;
              end else begin
                node_nxt  = IDX_W'(in_data.node_index);
                wt_nxt    = in_wt;
                state_nxt = S_SET_RD1;
              end
            end
            OP_SAMPLE: begin
              if (count_r == '0 || root_tot_r == '0) begin
                status_nxt = ST_ZERO_TOTAL;
                state_nxt  = S_DONE;
              end else begin
                rem_nxt   = (in_data.cutoff > root_tot_r) ? root_tot_r : in_data.cutoff;
                node_nxt  = '0;
                state_nxt = S_WALK_RD;
              end
            end
            default: begin
              status_nxt = ST_BAD_INDEX;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SET_RD1: begin
        t_raddr   = lc[IDX_W-1:0];
        state_nxt = S_SET_RD2;
      end

      S_SET_RD2: begin
        t_raddr     = rc[IDX_W-1:0];
        cur_tot_nxt = TOTAL_W'(wt_r) + (lc_ok ? t_rdata : '0);
        state_nxt   = S_SET_SUM;
      end

      S_SET_SUM: begin
        cur_tot_nxt = cur_tot_r + (rc_ok ? t_rdata : '0);
        state_nxt   = S_UP_START;
      end

      S_UP_START, S_UP: begin
        if (state_r == S_UP_START) begin
          w_we    = 1'b1;
          t_wdata = cur_tot_r;
        end else begin
          t_wdata     = up_sum;
          cur_tot_nxt = up_sum;
        end
        t_we = 1'b1;
        if (node_r == '0) begin
          root_tot_nxt = t_wdata;
          state_nxt    = S_DONE;
        end else begin
          // parent weight and sibling total arrive with the next cycle
          w_raddr    = par;
          t_raddr    = sib[IDX_W-1:0];
          sib_ok_nxt = 32'(sib) < 32'(count_r);
          node_nxt   = par;
          state_nxt  = S_UP;
        end
      end

      S_WALK_RD: begin
        w_raddr   = node_r;
        t_raddr   = lc[IDX_W-1:0];
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (take || !lc_ok || (go_right && !rc_ok)) begin
          chosen_nxt = NODE_IDX_W'(node_r);
          state_nxt  = S_DONE;
        end else begin
          rem_nxt  = go_right ? diff2[TOTAL_W-1:0] : diff;
          node_nxt = nxt_node[IDX_W-1:0];
          w_raddr  = nxt_node[IDX_W-1:0];
          t_raddr  = nxt_lc[IDX_W-1:0];
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/weighted_sum_tree_sampler.sv
// Weighted sum tree sampler: takes one request at a time and returns one result
// per request. A request is accepted, walks the tree one level per step, and
// hands its result to the output register. Append walks up from the new node
// to the root; set weight first reads the totals of the node's two children,
// then walks up likewise; sample walks down from the root. Invalid requests
// (tree full, bad index, sampling an empty or zero-weight tree, unknown
// operation) go straight to the result. The walk speed is set by the
// registered reads of the weight and total memories: each level needs that
// level's read before the next address is known.
// Memories need no clearing after reset; only entries of appended nodes are used.
// Depends on wst_pkg, wst_in_if, wst_out_if, wst_ram and wst_engine.
module weighted_sum_tree_sampler #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  wst_in_if.sink     in_ch,
  wst_out_if.source  out_ch
);
  import wst_pkg::*;

  logic     res_valid, res_ready;
  wst_out_t res_data;
  logic     out_valid_r;
  wst_out_t out_data_r;

  wst_engine #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // output register: result waits here while the engine takes the next request
  assign res_ready    = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule
